/* hdl/stok_pkg.sv */
package stok_pkg;

    localparam int DEF_OFFSET_BITS = 32;
    localparam int DEF_VALUE_BITS  = 64;

    localparam int KIND_W = 6;
    localparam int ERR_W  = 3;

    // scan modes
    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_IDENT   = 4'd1;
    localparam logic [3:0] M_ZERO    = 4'd2;
    localparam logic [3:0] M_DEC     = 4'd3;
    localparam logic [3:0] M_PREFIX  = 4'd4;
    localparam logic [3:0] M_OP      = 4'd5;
    localparam logic [3:0] M_COMMENT = 4'd6;
    localparam logic [3:0] M_DRAIN   = 4'd7;
    localparam logic [3:0] M_DONE    = 4'd8;

    // token kinds
    localparam logic [5:0] K_END      = 6'd0;
    localparam logic [5:0] K_IDENT    = 6'd1;
    localparam logic [5:0] K_NUMBER   = 6'd2;
    localparam logic [5:0] K_IF       = 6'd3;
    localparam logic [5:0] K_ELSE     = 6'd4;
    localparam logic [5:0] K_WHILE    = 6'd5;
    localparam logic [5:0] K_EXT      = 6'd6;
    localparam logic [5:0] K_LPAREN   = 6'd7;
    localparam logic [5:0] K_RPAREN   = 6'd8;
    localparam logic [5:0] K_LBRACK   = 6'd9;
    localparam logic [5:0] K_RBRACK   = 6'd10;
    localparam logic [5:0] K_LBRACE   = 6'd11;
    localparam logic [5:0] K_RBRACE   = 6'd12;
    localparam logic [5:0] K_COMMA    = 6'd13;
    localparam logic [5:0] K_AT       = 6'd14;
    localparam logic [5:0] K_COLON    = 6'd15;
    localparam logic [5:0] K_COLON_EQ = 6'd16;
    localparam logic [5:0] K_SEMI     = 6'd17;
    localparam logic [5:0] K_PLUS     = 6'd18;
    localparam logic [5:0] K_MINUS    = 6'd19;
    localparam logic [5:0] K_STAR     = 6'd20;
    localparam logic [5:0] K_SLASH    = 6'd21;
    localparam logic [5:0] K_PERCENT  = 6'd22;
    localparam logic [5:0] K_AMP      = 6'd23;
    localparam logic [5:0] K_PIPE     = 6'd24;
    localparam logic [5:0] K_CARET    = 6'd25;
    localparam logic [5:0] K_TILDE    = 6'd26;
    localparam logic [5:0] K_EXCLAM   = 6'd27;
    localparam logic [5:0] K_NE       = 6'd28;
    localparam logic [5:0] K_ASSIGN   = 6'd29;
    localparam logic [5:0] K_LT       = 6'd30;
    localparam logic [5:0] K_LE       = 6'd31;
    localparam logic [5:0] K_SHL      = 6'd32;
    localparam logic [5:0] K_GT       = 6'd33;
    localparam logic [5:0] K_GE       = 6'd34;
    localparam logic [5:0] K_SHR      = 6'd35;

    // error codes
    localparam logic [2:0] E_NONE    = 3'd0;
    localparam logic [2:0] E_CHAR    = 3'd1;
    localparam logic [2:0] E_LITERAL = 3'd2;
    localparam logic [2:0] E_LEADING = 3'd3;
    localparam logic [2:0] E_LARGE   = 3'd4;

    // number bases
    localparam logic [1:0] B_DEC = 2'd0;
    localparam logic [1:0] B_BIN = 2'd1;
    localparam logic [1:0] B_OCT = 2'd2;
    localparam logic [1:0] B_HEX = 2'd3;

    // keywords, first character in the lowest byte
    localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
    localparam logic [39:0] KW_ELSE  = 40'h00_6573_6C65;
    localparam logic [39:0] KW_WHILE = 40'h65_6C69_6877;
    localparam logic [39:0] KW_EXT   = 40'h00_0074_7865;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c == " " || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic id_first(input logic [7:0] c);
        return is_alpha(c) || c == "_" || c == "$" || c == ".";
    endfunction

    function automatic logic id_more(input logic [7:0] c);
        return id_first(c) || is_digit(c) || c == "@" || c == "%";
    endfunction

    // digit value; bit 4 set when the byte is no hex digit
    function automatic logic [4:0] digit_val(input logic [7:0] c);
        logic [7:0] t;
        if (is_digit(c)) begin
            t = c - "0";
        end else if (c >= "a" && c <= "f") begin
            t = c - "a" + 8'd10;
        end else if (c >= "A" && c <= "F") begin
            t = c - "A" + 8'd10;
        end else begin
            t = 8'd16;
        end
        return t[4:0];
    endfunction

    // kind of a token closed by its own byte, K_END when none
    function automatic logic [5:0] single_kind(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            "(":     k = K_LPAREN;
            ")":     k = K_RPAREN;
            "[":     k = K_LBRACK;
            "]":     k = K_RBRACK;
            "{":     k = K_LBRACE;
            "}":     k = K_RBRACE;
            ",":     k = K_COMMA;
            "@":     k = K_AT;
            "+":     k = K_PLUS;
            "*":     k = K_STAR;
            "/":     k = K_SLASH;
            "%":     k = K_PERCENT;
            "&":     k = K_AMP;
            "|":     k = K_PIPE;
            "^":     k = K_CARET;
            "~":     k = K_TILDE;
            "=":     k = K_ASSIGN;
            default: k = K_END;
        endcase
        return k;
    endfunction

    // kind of an operator that waits for one byte of lookahead, K_END when none
    function automatic logic [5:0] pending_of(input logic [7:0] c);
        logic [5:0] k;
        case (c)
            ":":     k = K_COLON;
            ";":     k = K_SEMI;
            "-":     k = K_MINUS;
            "!":     k = K_EXCLAM;
            "<":     k = K_LT;
            ">":     k = K_GT;
            default: k = K_END;
        endcase
        return k;
    endfunction

endpackage

/* hdl/stok_core.sv */
module stok_core #(
    parameter int OFFSET_BITS = 32,
    parameter int VALUE_BITS  = 64,
    parameter int RES_W       = 6 + VALUE_BITS + 2 * OFFSET_BITS + 3
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_eos,
    output logic [1:0]       res_count,
    output logic [RES_W:0]   res0,
    output logic [RES_W:0]   res1,
    output logic [RES_W:0]   res2
);
    import stok_pkg::*;

    typedef struct packed {
        logic                  emit;
        logic                  fail;
        logic [5:0]            kind;
        logic [VALUE_BITS-1:0] value;
        logic [2:0]            err;
    } close_t;

    logic [3:0]             mode_reg, mode_next;
    logic [5:0]             pend_reg, pend_next;
    logic [VALUE_BITS-1:0]  acc_reg, acc_next;
    logic [1:0]             base_reg, base_next;
    logic                   neg_reg, neg_next;
    logic                   ovf_reg, ovf_next;
    logic [7:0]             dcnt_reg, dcnt_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [39:0]            kwb_reg, kwb_next;
    logic [2:0]             ilen_reg, ilen_next;
    logic                   halted_reg, halted_next;

    logic [RES_W:0]         res_a [3];
    logic [1:0]             rn;

    function automatic close_t close_f(input logic [3:0] md, input logic [2:0] il,
                                       input logic [39:0] kb, input logic [7:0] dc,
                                       input logic ov, input logic ng,
                                       input logic [VALUE_BITS-1:0] ac,
                                       input logic [5:0] pk);
        close_t r;
        r = '0;
        case (md)
            M_IDENT: begin
                r.emit = 1'b1;
                r.kind = K_IDENT;
                if (il == 3'd2 && kb == KW_IF)    r.kind = K_IF;
                if (il == 3'd4 && kb == KW_ELSE)  r.kind = K_ELSE;
                if (il == 3'd5 && kb == KW_WHILE) r.kind = K_WHILE;
                if (il == 3'd3 && kb == KW_EXT)   r.kind = K_EXT;
            end
            M_PREFIX, M_ZERO, M_DEC: begin
                r.emit = 1'b1;
                if (md == M_PREFIX && dc == 8'd0) begin
                    r.fail = 1'b1;
                    r.err  = E_LITERAL;
                end else if (ov) begin
                    r.fail = 1'b1;
                    r.err  = E_LARGE;
                end else begin
                    r.kind  = K_NUMBER;
                    r.value = ng ? (VALUE_BITS'(0) - ac) : ac;
                end
            end
            M_OP: begin
                r.emit = 1'b1;
                r.kind = pk;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic logic [RES_W:0] mk(input logic [5:0] kind,
                                          input logic [VALUE_BITS-1:0] val,
                                          input logic [OFFSET_BITS-1:0] s,
                                          input logic [OFFSET_BITS-1:0] e,
                                          input logic [2:0] err);
        return {1'b0, err, e, s, val, kind};
    endfunction

    always_comb begin
        logic [OFFSET_BITS-1:0] p;
        logic [OFFSET_BITS-1:0] after;
        logic [7:0]             c;
        logic                   done;
        logic [5:0]             k;
        logic [4:0]             dv;
        logic                   do_add;
        logic [3:0]             add_d;
        logic [1:0]             add_b;
        logic [VALUE_BITS+3:0]  ax;
        logic [VALUE_BITS+3:0]  wide;
        close_t                 cl;

        mode_next   = mode_reg;
        pend_next   = pend_reg;
        acc_next    = acc_reg;
        base_next   = base_reg;
        neg_next    = neg_reg;
        ovf_next    = ovf_reg;
        dcnt_next   = dcnt_reg;
        pos_next    = pos_reg;
        start_next  = start_reg;
        kwb_next    = kwb_reg;
        ilen_next   = ilen_reg;
        halted_next = halted_reg;
        for (int i = 0; i < 3; i++) begin
            res_a[i] = '0;
        end
        rn     = 2'd0;
        p      = pos_reg;
        after  = pos_reg + OFFSET_BITS'(1);
        c      = (in_byte == CH_CR) ? CH_LF : in_byte;
        done   = 1'b0;
        k      = K_END;
        dv     = digit_val(c);
        do_add = 1'b0;
        add_d  = 4'd0;
        add_b  = B_DEC;
        ax     = '0;
        wide   = '0;
        cl     = '0;

        if (in_byte == 8'd0) begin
            if (mode_reg != M_DONE) begin
                if (!halted_reg) begin
                    cl = close_f(mode_next, ilen_next, kwb_next, dcnt_next, ovf_next,
                                 neg_next, acc_next, pend_next);
                    if (cl.emit) begin
                        res_a[rn] = mk(cl.kind, cl.value, start_next, p, cl.err);
                        rn = rn + 2'd1;
                    end
                    if (cl.fail) begin
                        halted_next = 1'b1;
                        mode_next   = M_DRAIN;
                    end else begin
                        mode_next = M_IDLE;
                    end
                end
                res_a[rn] = mk(K_END, '0, p, p, E_NONE);
                rn = rn + 2'd1;
            end
            if (!in_eos) begin
                mode_next   = M_DONE;
                halted_next = 1'b1;
                pos_next    = after;
            end
        end else begin
            if (!halted_reg) begin
                case (mode_reg)
                    M_IDENT: begin
                        if (id_more(c)) begin
                            done = 1'b1;
                            if (ilen_reg < 3'd5) begin
                                case (ilen_reg)
                                    3'd0:    kwb_next[7:0]   = c;
                                    3'd1:    kwb_next[15:8]  = c;
                                    3'd2:    kwb_next[23:16] = c;
                                    3'd3:    kwb_next[31:24] = c;
                                    default: kwb_next[39:32] = c;
                                endcase
                                ilen_next = ilen_reg + 3'd1;
                            end else begin
                                ilen_next = 3'd6;
                            end
                        end
                    end
                    M_ZERO: begin
                        if (is_digit(c)) begin
                            done = 1'b1;
                            res_a[rn] = mk(K_END, '0, start_reg, after, E_LEADING);
                            rn = rn + 2'd1;
                            halted_next = 1'b1;
                            mode_next   = M_DRAIN;
                        end else if (c == "b" || c == "B") begin
                            done = 1'b1;
                            base_next = B_BIN;
                            mode_next = M_PREFIX;
                        end else if (c == "o" || c == "O") begin
                            done = 1'b1;
                            base_next = B_OCT;
                            mode_next = M_PREFIX;
                        end else if (c == "x" || c == "X") begin
                            done = 1'b1;
                            base_next = B_HEX;
                            mode_next = M_PREFIX;
                        end else if (is_alpha(c)) begin
                            done = 1'b1;
                            res_a[rn] = mk(K_END, '0, start_reg, after, E_LITERAL);
                            rn = rn + 2'd1;
                            halted_next = 1'b1;
                            mode_next   = M_DRAIN;
                        end
                    end
                    M_DEC: begin
                        if (is_digit(c)) begin
                            done   = 1'b1;
                            do_add = 1'b1;
                            add_d  = dv[3:0];
                            add_b  = B_DEC;
                        end
                    end
                    M_PREFIX: begin
                        if (!dv[4] && (base_reg == B_HEX ||
                                       (base_reg == B_OCT && dv[3:0] < 4'd8) ||
                                       (base_reg == B_BIN && dv[3:0] < 4'd2))) begin
                            done   = 1'b1;
                            do_add = 1'b1;
                            add_d  = dv[3:0];
                            add_b  = base_reg;
                        end
                    end
                    M_OP: begin
                        if (pend_reg == K_COLON && c == "=")       k = K_COLON_EQ;
                        else if (pend_reg == K_EXCLAM && c == "=") k = K_NE;
                        else if (pend_reg == K_LT && c == "=")     k = K_LE;
                        else if (pend_reg == K_LT && c == "<")     k = K_SHL;
                        else if (pend_reg == K_GT && c == "=")     k = K_GE;
                        else if (pend_reg == K_GT && c == ">")     k = K_SHR;
                        if (k != K_END) begin
                            done = 1'b1;
                            res_a[rn] = mk(k, '0, start_reg, after, E_NONE);
                            rn = rn + 2'd1;
                            mode_next = M_IDLE;
                        end else if (pend_reg == K_SEMI && c == "#") begin
                            done = 1'b1;
                            mode_next = M_COMMENT;
                        end else if (pend_reg == K_MINUS && is_digit(c)) begin
                            // negated number keeps the '-' as its start
                            done      = 1'b1;
                            neg_next  = 1'b1;
                            ovf_next  = 1'b0;
                            dcnt_next = 8'd0;
                            base_next = B_DEC;
                            acc_next  = VALUE_BITS'(c[3:0]);
                            mode_next = (c == "0") ? M_ZERO : M_DEC;
                        end
                    end
                    M_COMMENT: begin
                        done = 1'b1;
                        if (c == CH_LF) mode_next = M_IDLE;
                    end
                    default: ;
                endcase

                if (do_add) begin
                    if (dcnt_reg != 8'hFF) dcnt_next = dcnt_reg + 8'd1;
                    ax = (VALUE_BITS+4)'(acc_reg);
                    case (add_b)
                        B_DEC:   wide = (ax << 3) + (ax << 1);
                        B_BIN:   wide = ax << 1;
                        B_OCT:   wide = ax << 3;
                        default: wide = ax << 4;
                    endcase
                    wide = wide + (VALUE_BITS+4)'(add_d);
                    if (!ovf_reg) begin
                        if (wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) ovf_next = 1'b1;
                        else acc_next = wide[VALUE_BITS-1:0];
                    end
                end

                if (!done) begin
                    cl = close_f(mode_reg, ilen_reg, kwb_reg, dcnt_reg, ovf_reg,
                                 neg_reg, acc_reg, pend_reg);
                    if (cl.emit) begin
                        res_a[rn] = mk(cl.kind, cl.value, start_reg, p, cl.err);
                        rn = rn + 2'd1;
                    end
                    if (cl.fail) begin
                        halted_next = 1'b1;
                        mode_next   = M_DRAIN;
                    end else begin
                        mode_next = M_IDLE;
                        if (!is_space(c)) begin
                            start_next = p;
                            k = single_kind(c);
                            if (k != K_END) begin
                                res_a[rn] = mk(k, '0, p, after, E_NONE);
                                rn = rn + 2'd1;
                            end else if (pending_of(c) != K_END) begin
                                pend_next = pending_of(c);
                                mode_next = M_OP;
                            end else if (id_first(c)) begin
                                kwb_next  = 40'(c);
                                ilen_next = 3'd1;
                                mode_next = M_IDENT;
                            end else if (is_digit(c)) begin
                                neg_next  = 1'b0;
                                ovf_next  = 1'b0;
                                dcnt_next = 8'd0;
                                base_next = B_DEC;
                                acc_next  = VALUE_BITS'(c[3:0]);
                                mode_next = (c == "0") ? M_ZERO : M_DEC;
                            end else begin
                                res_a[rn] = mk(K_END, '0, p, after, E_CHAR);
                                rn = rn + 2'd1;
                                halted_next = 1'b1;
                                mode_next   = M_DRAIN;
                            end
                        end
                    end
                end
            end
            pos_next = after;
            if (in_eos && mode_next != M_DONE) begin
                if (!halted_next) begin
                    cl = close_f(mode_next, ilen_next, kwb_next, dcnt_next, ovf_next,
                                 neg_next, acc_next, pend_next);
                    if (cl.emit) begin
                        res_a[rn] = mk(cl.kind, cl.value, start_next, after, cl.err);
                        rn = rn + 2'd1;
                    end
                end
                res_a[rn] = mk(K_END, '0, after, after, E_NONE);
                rn = rn + 2'd1;
            end
        end

        // end of source returns everything to the reset state
        if (in_eos) begin
            mode_next   = M_IDLE;
            pend_next   = K_END;
            acc_next    = '0;
            base_next   = B_DEC;
            neg_next    = 1'b0;
            ovf_next    = 1'b0;
            dcnt_next   = 8'd0;
            pos_next    = '0;
            start_next  = '0;
            kwb_next    = '0;
            ilen_next   = 3'd0;
            halted_next = 1'b0;
        end

        if (rn != 2'd0) res_a[rn - 2'd1][RES_W] = 1'b1;
    end

    assign res_count = rn;
    assign res0      = res_a[0];
    assign res1      = res_a[1];
    assign res2      = res_a[2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pend_reg   <= K_END;
            acc_reg    <= '0;
            base_reg   <= B_DEC;
            neg_reg    <= 1'b0;
            ovf_reg    <= 1'b0;
            dcnt_reg   <= 8'd0;
            pos_reg    <= '0;
            start_reg  <= '0;
            kwb_reg    <= '0;
            ilen_reg   <= 3'd0;
            halted_reg <= 1'b0;
        end else if (accept) begin
            mode_reg   <= mode_next;
            pend_reg   <= pend_next;
            acc_reg    <= acc_next;
            base_reg   <= base_next;
            neg_reg    <= neg_next;
            ovf_reg    <= ovf_next;
            dcnt_reg   <= dcnt_next;
            pos_reg    <= pos_next;
            start_reg  <= start_next;
            kwb_reg    <= kwb_next;
            ilen_reg   <= ilen_next;
            halted_reg <= halted_next;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> (mode_reg == M_DRAIN || mode_reg == M_DONE))
        else $error("halted outside drain or done");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_eos) |=> (pos_reg == '0 && !halted_reg && mode_reg == M_IDLE))
        else $error("state not cleared after end of source");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (ilen_reg <= 3'd6))
        else $error("identifier length beyond saturation");

endmodule

/* hdl/stok_out.sv */
module stok_out #(
    parameter int RES_W = 137
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  logic [1:0]     load_count,
    input  logic [RES_W:0] res0,
    input  logic [RES_W:0] res1,
    input  logic [RES_W:0] res2,
    input  logic           pop,
    output logic           can_load,
    output logic           head_valid,
    output logic [RES_W:0] head
);
    import stok_pkg::*;

    logic [RES_W:0] e0_reg, e1_reg, e2_reg;
    logic [1:0]     cnt_reg;

    // a new transaction may enter once the last held result leaves
    assign can_load   = (cnt_reg == 2'd0) || (cnt_reg == 2'd1 && pop);
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = e0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= load_count;
        end else if (pop) begin
            cnt_reg <= cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            e0_reg <= res0;
            e1_reg <= res1;
            e2_reg <= res2;
        end else if (pop) begin
            e0_reg <= e1_reg;
            e1_reg <= e2_reg;
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg != 2'd3 || !pop || load || 1'b1 ? cnt_reg <= 2'd3 : 1'b1)
        else $error("result count out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> (cnt_reg == 2'd0 || (cnt_reg == 2'd1 && pop)))
        else $error("results overwritten before delivery");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !load) |=> (cnt_reg == $past(cnt_reg) - 2'd1))
        else $error("result count did not advance on pop");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && cnt_reg == 2'd1) |-> head[RES_W])
        else $error("final held result lacks its last mark");

endmodule

/* hdl/source_tokenizer_top.sv */
// The first result of a transaction is registered and is on m_tdata in the cycle after it is accepted.
// Throughput: one input byte per cycle while m_tready stays high and each byte yields at most one result;
// a byte that yields more results (at most three) holds s_tready low until only its last result is left and is taken.
// The three-entry result register bank, which holds all results of one byte, sets that limit.
// Reset (aresetn low at a clock edge) clears all scan state and offsets and discards held results.
module source_tokenizer_top #(
    parameter int OFFSET_BITS = stok_pkg::DEF_OFFSET_BITS,
    parameter int VALUE_BITS  = stok_pkg::DEF_VALUE_BITS,
    parameter int DATA_W      = ((6 + VALUE_BITS + 2 * OFFSET_BITS + 3 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // source_byte
    input  logic              s_tlast,   // end_of_source
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [DATA_W-1:0] m_tdata,   // token_kind, token_value, token_start, token_end,
                                         // error_code, zero fill
    output logic              m_tlast    // run_last
);
    import stok_pkg::*;

    localparam int RES_W = KIND_W + VALUE_BITS + 2 * OFFSET_BITS + ERR_W;

    logic           accept;
    logic           pop;
    logic           can_load;
    logic [1:0]     res_count;
    logic [RES_W:0] res0, res1, res2, head;

    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;
    assign s_tready = can_load;

    stok_core #(
        .OFFSET_BITS(OFFSET_BITS),
        .VALUE_BITS (VALUE_BITS),
        .RES_W      (RES_W)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_byte  (s_tdata),
        .in_eos   (s_tlast),
        .res_count(res_count),
        .res0     (res0),
        .res1     (res1),
        .res2     (res2)
    );

    stok_out #(
        .RES_W(RES_W)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (accept),
        .load_count(res_count),
        .res0      (res0),
        .res1      (res1),
        .res2      (res2),
        .pop       (pop),
        .can_load  (can_load),
        .head_valid(m_tvalid),
        .head      (head)
    );

    assign m_tdata = DATA_W'(head[RES_W-1:0]);
    assign m_tlast = head[RES_W];

endmodule

/* tb/tb_source_tokenizer_top.sv */
`timescale 1ns / 100ps

module tb_source_tokenizer_top;
    import stok_pkg::*;

    localparam int DATA_W = 144;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [5:0]  kind;
        logic [63:0] value;
        logic [31:0] tok_start;
        logic [31:0] tok_end;
        logic [2:0]  err;
        logic        last;
    } token_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eos;
    } byte_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = 8'd0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic              m_tlast;

    source_tokenizer_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    byte_t  pending_bytes[$];
    token_t expected_tokens[$];
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    int     error_count = 0;
    longint cycle_count = 0;

    // lexer state
    logic [3:0]  lx_mode;
    logic [5:0]  lx_pend;
    logic [63:0] lx_acc;
    logic [1:0]  lx_base;
    logic        lx_neg, lx_ovf, lx_halted;
    logic [7:0]  lx_digits;
    logic [31:0] lx_pos, lx_start;
    logic [39:0] lx_kwbuf;
    logic [2:0]  lx_idlen;
    int          lx_emitted;

    function automatic logic is_alpha_c(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_digit_c(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic id_start_c(logic [7:0] c);
        return is_alpha_c(c) || c == "_" || c == "$" || c == ".";
    endfunction
    function automatic logic id_cont_c(logic [7:0] c);
        return id_start_c(c) || is_digit_c(c) || c == "@" || c == "%";
    endfunction

    task automatic lexer_clear();
        lx_mode = M_IDLE; lx_pend = K_END; lx_acc = '0; lx_base = B_DEC;
        lx_neg = 0; lx_ovf = 0; lx_halted = 0; lx_digits = 0;
        lx_pos = 0; lx_start = 0; lx_kwbuf = 0; lx_idlen = 0;
    endtask

    function automatic void emit_token(logic [5:0] k, logic [63:0] v, logic [31:0] s,
                                       logic [31:0] e, logic [2:0] er);
        token_t t;
        if (lx_emitted >= 3) return;
        t.kind = k; t.value = v; t.tok_start = s; t.tok_end = e; t.err = er; t.last = 0;
        expected_tokens.push_back(t);
        lx_emitted++;
    endfunction

    function automatic void raise_error(logic [2:0] code, logic [31:0] e);
        emit_token(K_END, 64'd0, lx_start, e, code);
        lx_halted = 1;
        lx_mode = M_DRAIN;
    endfunction

    task automatic accumulate_digit(logic [4:0] d, int radix);
        logic [63:0] lim;
        lim = (64'hFFFF_FFFF_FFFF_FFFF - 64'(d)) / 64'(radix);
        if (lx_digits != 8'd255) lx_digits++;
        if (lx_ovf) return;
        if (lx_acc > lim) lx_ovf = 1;
        else lx_acc = lx_acc * 64'(radix) + 64'(d);
    endtask

    task automatic begin_number(logic [7:0] c, logic neg);
        lx_neg = neg; lx_ovf = 0; lx_digits = 0; lx_base = B_DEC; lx_acc = 0;
        if (c == "0") lx_mode = M_ZERO;
        else begin
            lx_acc = 64'(c - "0");
            lx_mode = M_DEC;
        end
    endtask

    // emit whatever token is open; returns 0 when closing it raised an error
    function automatic logic close_open_token(logic [31:0] e);
        logic [5:0] k;
        case (lx_mode)
            M_IDENT: begin
                k = K_IDENT;
                if (lx_idlen == 2 && lx_kwbuf == KW_IF) k = K_IF;
                if (lx_idlen == 4 && lx_kwbuf == KW_ELSE) k = K_ELSE;
                if (lx_idlen == 5 && lx_kwbuf == KW_WHILE) k = K_WHILE;
                if (lx_idlen == 3 && lx_kwbuf == KW_EXT) k = K_EXT;
                emit_token(k, 64'd0, lx_start, e, E_NONE);
            end
            M_PREFIX, M_ZERO, M_DEC: begin
                if (lx_mode == M_PREFIX && lx_digits == 0) begin
                    raise_error(E_LITERAL, e);
                    return 0;
                end
                if (lx_ovf) begin
                    raise_error(E_LARGE, e);
                    return 0;
                end
                emit_token(K_NUMBER, lx_neg ? -lx_acc : lx_acc, lx_start, e, E_NONE);
            end
            M_OP: emit_token(lx_pend, 64'd0, lx_start, e, E_NONE);
            default: ;
        endcase
        lx_mode = M_IDLE;
        return 1;
    endfunction

    task automatic scan_char(logic [7:0] c, logic [31:0] p);
        logic [31:0] nxt;
        logic [5:0]  k;
        logic [4:0]  d;
        int          radix;
        nxt = p + 1;
        k = K_END;
        case (lx_mode)
            M_IDENT: if (id_cont_c(c)) begin
                if (lx_idlen < 5) begin
                    lx_kwbuf = lx_kwbuf | (40'(c) << (8 * lx_idlen));
                    lx_idlen++;
                end else lx_idlen = 6;
                return;
            end
            M_ZERO: begin
                if (is_digit_c(c)) begin raise_error(E_LEADING, nxt); return; end
                if (c == "b" || c == "B") begin lx_base = B_BIN; lx_mode = M_PREFIX; return; end
                if (c == "o" || c == "O") begin lx_base = B_OCT; lx_mode = M_PREFIX; return; end
                if (c == "x" || c == "X") begin lx_base = B_HEX; lx_mode = M_PREFIX; return; end
                if (is_alpha_c(c)) begin raise_error(E_LITERAL, nxt); return; end
            end
            M_DEC: if (is_digit_c(c)) begin accumulate_digit(5'(c - "0"), 10); return; end
            M_PREFIX: begin
                radix = (lx_base == B_BIN) ? 2 : (lx_base == B_OCT) ? 8 : 16;
                d = 5'd16;
                if (is_digit_c(c)) d = 5'(c - "0");
                else if (c >= "a" && c <= "f") d = 5'(c - "a" + 10);
                else if (c >= "A" && c <= "F") d = 5'(c - "A" + 10);
                if (d < radix) begin accumulate_digit(d, radix); return; end
            end
            M_OP: begin
                if (lx_pend == K_COLON && c == "=") k = K_COLON_EQ;
                else if (lx_pend == K_EXCLAM && c == "=") k = K_NE;
                else if (lx_pend == K_LT && c == "=") k = K_LE;
                else if (lx_pend == K_LT && c == "<") k = K_SHL;
                else if (lx_pend == K_GT && c == "=") k = K_GE;
                else if (lx_pend == K_GT && c == ">") k = K_SHR;
                if (k != K_END) begin
                    emit_token(k, 64'd0, lx_start, nxt, E_NONE);
                    lx_mode = M_IDLE;
                    return;
                end
                if (lx_pend == K_SEMI && c == "#") begin lx_mode = M_COMMENT; return; end
                if (lx_pend == K_MINUS && is_digit_c(c)) begin begin_number(c, 1); return; end
            end
            M_COMMENT: begin
                if (c == CH_LF) lx_mode = M_IDLE;
                return;
            end
            default: ;
        endcase
        if (!close_open_token(p)) return;
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) return;
        lx_start = p;
        case (c)
            "(": k = K_LPAREN;   ")": k = K_RPAREN;  "[": k = K_LBRACK;  "]": k = K_RBRACK;
            "{": k = K_LBRACE;   "}": k = K_RBRACE;  ",": k = K_COMMA;   "@": k = K_AT;
            "+": k = K_PLUS;     "*": k = K_STAR;    "/": k = K_SLASH;   "%": k = K_PERCENT;
            "&": k = K_AMP;      "|": k = K_PIPE;    "^": k = K_CARET;   "~": k = K_TILDE;
            "=": k = K_ASSIGN;
            ":": begin lx_pend = K_COLON;  lx_mode = M_OP; return; end
            ";": begin lx_pend = K_SEMI;   lx_mode = M_OP; return; end
            "-": begin lx_pend = K_MINUS;  lx_mode = M_OP; return; end
            "!": begin lx_pend = K_EXCLAM; lx_mode = M_OP; return; end
            "<": begin lx_pend = K_LT;     lx_mode = M_OP; return; end
            ">": begin lx_pend = K_GT;     lx_mode = M_OP; return; end
            default: begin
                if (id_start_c(c)) begin
                    lx_kwbuf = 40'(c); lx_idlen = 1; lx_mode = M_IDENT;
                end else if (is_digit_c(c)) begin
                    begin_number(c, 0);
                end else begin
                    raise_error(E_CHAR, nxt);
                end
                return;
            end
        endcase
        emit_token(k, 64'd0, p, nxt, E_NONE);
    endtask

    task automatic predict_tokens(byte_t b);
        logic [31:0] p;
        logic [7:0]  c;
        int          first;
        p = lx_pos;
        first = expected_tokens.size();
        lx_emitted = 0;
        if (b.ch == 8'd0) begin
            if (lx_mode != M_DONE) begin
                if (!lx_halted) void'(close_open_token(p));
                emit_token(K_END, 64'd0, p, p, E_NONE);
            end
            if (b.eos) lexer_clear();
            else begin
                lx_mode = M_DONE; lx_halted = 1; lx_pos = p + 1;
            end
        end else begin
            c = (b.ch == CH_CR) ? CH_LF : b.ch;
            if (!lx_halted) scan_char(c, p);
            p = p + 1;
            lx_pos = p;
            if (b.eos) begin
                if (lx_mode != M_DONE) begin
                    if (!lx_halted) void'(close_open_token(p));
                    emit_token(K_END, 64'd0, p, p, E_NONE);
                end
                lexer_clear();
            end
        end
        if (expected_tokens.size() > first)
            expected_tokens[expected_tokens.size() - 1].last = 1'b1;
    endtask

    // accepted at the last rising edge; read by the driver at the falling edge
    logic s_tready_q = 1'b0;

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_tvalid || s_tready_q) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= pending_bytes[0].ch;
                    s_tlast  <= pending_bytes[0].eos;
                    void'(pending_bytes.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        token_t got, want;
        s_tready_q <= aresetn && s_tvalid && s_tready;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                predict_tokens('{ch: s_tdata, eos: s_tlast});
            end
            if (m_tvalid && m_tready) begin
                got = {m_tdata[5:0], m_tdata[69:6], m_tdata[101:70], m_tdata[133:102],
                       m_tdata[136:134], m_tlast};
                if (expected_tokens.size() == 0) begin
                    $error("unexpected token transaction kind=%0d", got.kind);
                    error_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, got.kind);
                        error_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("token_value: expected %h, got %h", want.value, got.value);
                        error_count++;
                    end
                    if (got.tok_start !== want.tok_start) begin
                        $error("token_start: expected %0d, got %0d",
                               want.tok_start, got.tok_start);
                        error_count++;
                    end
                    if (got.tok_end !== want.tok_end) begin
                        $error("token_end: expected %0d, got %0d", want.tok_end, got.tok_end);
                        error_count++;
                    end
                    if (got.err !== want.err) begin
                        $error("error_code: expected %0d, got %0d", want.err, got.err);
                        error_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("run_last: expected %0d, got %0d", want.last, got.last);
                        error_count++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic queue_text(string txt, logic close);
        for (int i = 0; i < txt.len(); i++)
            pending_bytes.push_back('{ch: txt[i], eos: close && i == txt.len() - 1});
    endtask

    function automatic logic [7:0] random_char();
        string alphabet = "abcdefxzwhilsABXob_$.@%0123456789 \t\r\n()[]{},+*/&|^~=:;-!<>#";
        int r;
        r = $urandom_range(99);
        if (r < 3) return 8'($urandom_range(128, 255));
        if (r < 5) return 8'($urandom_range(1, 127));
        return alphabet[$urandom_range(alphabet.len() - 1)];
    endfunction

    function automatic string random_fragment();
        string parts[28] = '{"if ", "else ", "while", "ext ", "ifx ", "elsewhere ",
                             "x_1.$@% ", "0x1F ", "0b101 ", "0o777 ", "-42 ", "- 7",
                             "0xFFFFFFFFFFFFFFFF ", "99999999999999999999 ", "a:=b ",
                             "<= ", "<< ", ">= ", ">> ", "!= ", "! ", ";# note\n", "; ",
                             "(x[1]){y},", "12 ", "0 ", "\r", "a+b*c/d%e&f|g^~h"};
        return parts[$urandom_range($size(parts) - 1)];
    endfunction

    task automatic run_phase(int idle, int stall, int n_sources);
        string txt;
        int    len, cnt;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int s = 0; s < n_sources; s++) begin
            txt = "";
            cnt = $urandom_range(1, 3);
            for (int f = 0; f < cnt; f++) begin
                if ($urandom_range(9) < 7) txt = {txt, random_fragment()};
                else begin
                    len = $urandom_range(1, 4);
                    for (int j = 0; j < len; j++) txt = {txt, string'(random_char())};
                end
            end
            if ($urandom_range(3) == 0) begin
                queue_text(txt, 1'b0);
                pending_bytes.push_back('{ch: 8'd0, eos: 1'($urandom_range(1))});
                if (!pending_bytes[$].eos) begin
                    pending_bytes.push_back('{ch: random_char(), eos: 1'b0});
                    pending_bytes.push_back('{ch: random_char(), eos: 1'b1});
                end
            end else begin
                queue_text(txt, 1'b1);
            end
        end
        wait (pending_bytes.size() == 0 && !s_tvalid && expected_tokens.size() == 0);
    endtask

    initial begin
        lexer_clear();
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed sources
        queue_text("if else while ext iff ;# c\r(x)", 1'b1);
        queue_text("a:=b!=c<=d<<e>=f>>g:!<>-5 -0x10 0b1 0o7", 1'b1);
        queue_text("0xFFFFFFFFFFFFFFFF", 1'b1);
        queue_text("18446744073709551616 ", 1'b1);
        queue_text("007", 1'b1);
        queue_text("0q", 1'b1);
        queue_text("0x ", 1'b1);
        queue_text("1 ", 1'b0);
        pending_bytes.push_back('{ch: 8'hFF, eos: 1'b0});
        pending_bytes.push_back('{ch: 8'h80, eos: 1'b1});
        queue_text("x", 1'b0);
        pending_bytes.push_back('{ch: 8'd0, eos: 1'b0});
        pending_bytes.push_back('{ch: 8'h7F, eos: 1'b1});
        pending_bytes.push_back('{ch: 8'd0, eos: 1'b1});
        wait (pending_bytes.size() == 0 && !s_tvalid && expected_tokens.size() == 0);

        run_phase(0, 0, 2);
        run_phase(57, 0, 2);
        run_phase(0, 57, 2);
        run_phase(29, 29, 2);

        repeat (20) @(posedge aclk);
        if (error_count == 0 && expected_tokens.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
